// File: rtl/slpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_pkg: shared definitions for the slot pool free list
// Request and result codes, field widths, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package slpf_pkg;

   localparam int FUNC_W   = 3;
   localparam int IDX_W    = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 9;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic load;
      logic op_add;
      logic op_remove;
      logic op_get;
      logic op_next;
      logic op_clear;
      logic op_nop;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/slot_pool_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_pool_free_list: fixed slot pool with a free index stack
// Each request gives exactly one result, shown for one cycle with rsp_strobe
// high; the receiver cannot stall it. An add, remove, get, clear or unused
// code is handled in the cycle the request is taken, in which the entry,
// free flag and free stack memories are read, and then in an operation
// state that updates the counters, writes the memories and loads the result
// register. A next request stays in its scan state for every freed slot it
// skips, since the cursor steps through the free flag memory one slot per
// cycle. The result appears in the cycle after the request ends, and a new
// request may be taken in that same cycle. No clearing pass runs after reset
// or clear: only slots below the used mark are ever read.
// ----------------------------------------------------------------------------
module slot_pool_free_list #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [slpf_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [slpf_pkg::IDX_W-1:0]       req_slot_index,
   input  wire logic [slpf_pkg::DATA_W-1:0]      req_entry_data,
   output logic                                  rsp_strobe,
   output logic      [slpf_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [slpf_pkg::IDX_W-1:0]       rsp_result_index,
   output logic      [slpf_pkg::DATA_W-1:0]      rsp_result_data,
   output logic      [slpf_pkg::LIVE_W-1:0]      rsp_live_count
);

   import slpf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   slpf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_func (req_func),
      .cmd      (cmd),
      .sts      (sts)
   );

   slpf_dp #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_slot_index   (req_slot_index),
      .req_entry_data   (req_entry_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_result_data  (rsp_result_data),
      .rsp_live_count   (rsp_live_count)
   );

endmodule
`default_nettype wire

// File: rtl/slpf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module slpf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/slpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_ctrl: request sequencer for the slot pool free list
// Takes a request when idle, runs its operation step, and holds the
// cursor scan of a next request until the datapath reports it finished.
// ----------------------------------------------------------------------------
module slpf_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [slpf_pkg::FUNC_W-1:0]    req_func,
   output slpf_pkg::cmd_type                   cmd,
   input  wire slpf_pkg::sts_type              sts
);

   import slpf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD    = 3'd1;
   localparam logic [2:0] S_REMOVE = 3'd2;
   localparam logic [2:0] S_GET    = 3'd3;
   localparam logic [2:0] S_NEXT   = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;
   localparam logic [2:0] S_NOP    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ADD:    state_in = S_ADD;
                  FUNC_REMOVE: state_in = S_REMOVE;
                  FUNC_GET:    state_in = S_GET;
                  FUNC_NEXT:   state_in = S_NEXT;
                  FUNC_CLEAR:  state_in = S_CLEAR;
                  default:     state_in = S_NOP;
               endcase
            end
         end
         S_NEXT: begin
            if (sts.scan_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.op_add    = (state_ff == S_ADD);
      cmd.op_remove = (state_ff == S_REMOVE);
      cmd.op_get    = (state_ff == S_GET);
      cmd.op_next   = (state_ff == S_NEXT);
      cmd.op_clear  = (state_ff == S_CLEAR);
      cmd.op_nop    = (state_ff == S_NOP);
   end

endmodule
`default_nettype wire

// File: rtl/slpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_dp: datapath of the slot pool free list
// Holds the entry, free flag and free stack memories, the stack depth,
// used mark and live counters, the scan cursor and the result register.
// ----------------------------------------------------------------------------
module slpf_dp #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire slpf_pkg::cmd_type                cmd,
   output slpf_pkg::sts_type                     sts,
   input  wire logic [slpf_pkg::IDX_W-1:0]       req_slot_index,
   input  wire logic [slpf_pkg::DATA_W-1:0]      req_entry_data,
   output logic                                  rsp_strobe,
   output logic      [slpf_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [slpf_pkg::IDX_W-1:0]       rsp_result_index,
   output logic      [slpf_pkg::DATA_W-1:0]      rsp_result_data,
   output logic      [slpf_pkg::LIVE_W-1:0]      rsp_live_count
);

   import slpf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   logic [CW-1:0]       sd_ff, sd_in;
   logic [CW-1:0]       mark_ff, mark_in;
   logic [CW-1:0]       live_ff, live_in;
   logic [XW-1:0]       cursor_ff, cursor_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;

   logic [CW-1:0]       sd_dec;
   logic [XW-1:0]       mark_x;
   logic [XW-1:0]       slot_x;
   logic [AW-1:0]       slot;
   logic                below;
   logic                full;
   logic                is_top;

   logic                entry_we;
   logic [AW-1:0]       entry_waddr;
   logic [WIDTH-1:0]    entry_wdata;
   logic [WIDTH-1:0]    entry_rd;
   logic                flag_we;
   logic [AW-1:0]       flag_waddr;
   logic                flag_wdata;
   logic                flag_rd;
   logic                stack_we;
   logic [AW-1:0]       stack_rd;

   logic [DATA_W+WIDTH-1:0] wdata_ext;
   logic [WIDTH+DATA_W-1:0] rdata_ext;
   logic [CW+LIVE_W-1:0]    live_ext;

   assign sd_dec    = sd_ff - 1'b1;
   assign mark_x    = XW'(mark_ff);
   assign below     = (cursor_ff < mark_x);
   assign full      = (sd_ff == '0) && (mark_ff == CW'(DEPTH));
   assign is_top    = ((cursor_ff + 1'b1) == mark_x);
   assign slot      = (sd_ff != '0) ? stack_rd : mark_ff[AW-1:0];
   assign slot_x    = XW'(slot);
   assign wdata_ext = {{WIDTH{1'b0}}, data_ff};
   assign rdata_ext = {{DATA_W{1'b0}}, entry_rd};
   assign live_ext  = {{LIVE_W{1'b0}}, live_ff};

   assign sts.scan_done = !below || !flag_rd;

   assign entry_waddr = slot;
   assign entry_wdata = wdata_ext[WIDTH-1:0];
   assign flag_waddr  = cmd.op_add ? slot : cursor_ff[AW-1:0];
   assign flag_wdata  = cmd.op_remove;

   always_comb begin
      sd_in     = sd_ff;
      mark_in   = mark_ff;
      live_in   = live_ff;
      cursor_in = cursor_ff;
      data_in   = data_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      index_in  = index_ff;
      rdata_in  = rdata_ff;
      entry_we  = 1'b0;
      flag_we   = 1'b0;
      stack_we  = 1'b0;

      if (cmd.load) begin
         cursor_in = XW'(req_slot_index);
         data_in   = req_entry_data;
      end

      if (cmd.op_add || cmd.op_remove || cmd.op_get || cmd.op_clear || cmd.op_nop) begin
         strobe_in = 1'b1;
         status_in = ST_OK;
         index_in  = '0;
         rdata_in  = '0;
      end

      if (cmd.op_add) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            entry_we = 1'b1;
            flag_we  = 1'b1;
            live_in  = live_ff + 1'b1;
            index_in = slot_x[IDX_W-1:0];
            if (sd_ff != '0) begin
               sd_in = sd_dec;
            end else begin
               mark_in = mark_ff + 1'b1;
            end
         end
      end

      if (cmd.op_remove) begin
         if (!below) begin
            status_in = ST_RANGE;
         end else if (flag_rd) begin
            status_in = ST_FREED;
         end else begin
            flag_we = 1'b1;
            live_in = live_ff - 1'b1;
            if (is_top) begin
               mark_in = mark_ff - 1'b1;
            end else if (sd_ff < CW'(DEPTH)) begin
               stack_we = 1'b1;
               sd_in    = sd_ff + 1'b1;
            end
         end
      end

      if (cmd.op_get) begin
         if (!below) begin
            status_in = ST_RANGE;
         end else begin
            rdata_in = rdata_ext[DATA_W-1:0];
         end
      end

      if (cmd.op_clear) begin
         sd_in   = '0;
         mark_in = '0;
         live_in = '0;
      end

      if (cmd.op_next) begin
         if (!below) begin
            strobe_in = 1'b1;
            status_in = ST_NOT_FOUND;
            index_in  = '0;
            rdata_in  = '0;
         end else if (!flag_rd) begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            index_in  = cursor_ff[IDX_W-1:0];
            rdata_in  = rdata_ext[DATA_W-1:0];
         end else begin
            cursor_in = cursor_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff     <= '0;
         mark_ff   <= '0;
         live_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sd_ff     <= sd_in;
         mark_ff   <= mark_in;
         live_ff   <= live_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      rdata_ff  <= rdata_in;
   end

   slpf_ram #(
      .DATA_W (WIDTH),
      .DEPTH  (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wdata),
      .rd_addr (cursor_in[AW-1:0]),
      .rd_data (entry_rd)
   );

   slpf_ram #(
      .DATA_W (1),
      .DEPTH  (DEPTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (cursor_in[AW-1:0]),
      .rd_data (flag_rd)
   );

   slpf_ram #(
      .DATA_W (AW),
      .DEPTH  (DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (sd_ff[AW-1:0]),
      .wr_data (cursor_ff[AW-1:0]),
      .rd_addr (sd_dec[AW-1:0]),
      .rd_data (stack_rd)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_index = index_ff;
   assign rsp_result_data  = rdata_ff;
   assign rsp_live_count   = live_ext[LIVE_W-1:0];

endmodule
`default_nettype wire

// File: bench/tb_slot_pool_free_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slot_pool_free_list: self-checking bench for the slot pool free list
// Requests go in through the start/busy handshake in bursts with random
// gaps, or back to back in one randomized run. A behavioral model of the
// pool tracks the payloads, the free flags, the free index stack, the used
// mark and the live count, and predicts the one result of each accepted
// request. A monitor compares every strobed result with the oldest
// prediction. The tests cover the empty pool, each operation and its error
// codes, a completely full pool with long scans, and a long randomized mix.
// ----------------------------------------------------------------------------
module tb_slot_pool_free_list;
   import slpf_pkg::*;

   localparam int POOL_DEPTH = 256;
   localparam int FUNC_CODES = 1 << FUNC_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [DATA_W-1:0]   data;
      logic [LIVE_W-1:0]   live;
   } pool_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [FUNC_W-1:0]   req_func = FUNC_ADD;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic [DATA_W-1:0]   req_entry_data = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic [DATA_W-1:0]   rsp_result_data;
   logic [LIVE_W-1:0]   rsp_live_count;

   logic [DATA_W-1:0] slot_payload [POOL_DEPTH];
   bit                slot_is_free [POOL_DEPTH];
   logic [IDX_W-1:0]  recycle_stack [POOL_DEPTH];
   int                recycle_depth = 0;
   int                high_water = 0;
   int                live_total = 0;

   pool_result_type expected_results [$];
   int error_count = 0;
   int result_count = 0;
   int request_count = 0;
   int op_tally [FUNC_CODES];
   int status_tally [FUNC_CODES];
   bit sender_pauses = 1'b1;
   int burst_left = 0;

   slot_pool_free_list #(
      .DEPTH(POOL_DEPTH),
      .WIDTH(DATA_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_slot_index(req_slot_index),
      .req_entry_data(req_entry_data),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_result_index(rsp_result_index),
      .rsp_result_data(rsp_result_data),
      .rsp_live_count(rsp_live_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pool_result_type predict_response(logic [FUNC_W-1:0] func,
                                                        logic [IDX_W-1:0] idx,
                                                        logic [DATA_W-1:0] data);
      pool_result_type r;
      int slot;
      int i;
      r = '0;
      r.status = ST_OK;
      case (func)
         FUNC_ADD: begin
            slot = -1;
            if (recycle_depth > 0) begin
               recycle_depth--;
               slot = recycle_stack[recycle_depth];
            end else if (high_water < POOL_DEPTH) begin
               slot = high_water;
               high_water++;
            end
            if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_payload[slot] = data;
               slot_is_free[slot] = 1'b0;
               live_total++;
               r.index = IDX_W'(slot);
            end
         end
         FUNC_REMOVE: begin
            if (idx >= high_water) begin
               r.status = ST_RANGE;
            end else if (slot_is_free[idx]) begin
               r.status = ST_FREED;
            end else begin
               slot_is_free[idx] = 1'b1;
               if (live_total > 0) live_total--;
               if (idx + 1 == high_water) begin
                  high_water--;
               end else if (recycle_depth < POOL_DEPTH) begin
                  recycle_stack[recycle_depth] = idx;
                  recycle_depth++;
               end
            end
         end
         FUNC_GET: begin
            if (idx >= high_water) r.status = ST_RANGE;
            else r.data = slot_payload[idx];
         end
         FUNC_NEXT: begin
            i = idx;
            while (i < high_water && slot_is_free[i]) i++;
            if (i < high_water) begin
               r.index = IDX_W'(i);
               r.data = slot_payload[i];
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         FUNC_CLEAR: begin
            for (int k = 0; k < POOL_DEPTH; k++) slot_is_free[k] = 1'b0;
            recycle_depth = 0;
            high_water = 0;
            live_total = 0;
         end
         default: begin
         end
      endcase
      r.live = LIVE_W'(live_total);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] near_slot();
      if (high_water == 0 || $urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 255));
      return IDX_W'($urandom_range(0, (high_water > 255) ? 255 : high_water));
   endfunction

   function automatic logic [IDX_W-1:0] pick_live_slot();
      int slot;
      if (live_total == 0) return near_slot();
      slot = 0;
      for (int tries = 0; tries < 16; tries++) begin
         slot = $urandom_range(0, high_water - 1);
         if (!slot_is_free[slot]) break;
      end
      return IDX_W'(slot);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t, result %0d: %s", $time, result_count, msg);
      error_count++;
   endtask

   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] data);
      pool_result_type prediction;
      if (sender_pauses && burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0) burst_left--;
      start <= 1'b1;
      req_func <= func;
      req_slot_index <= idx;
      req_entry_data <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      prediction = predict_response(func, idx, data);
      expected_results.push_back(prediction);
      request_count++;
      op_tally[func]++;
      status_tally[prediction.status]++;
   endtask

   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result with status %0d", rsp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_error($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_result_index !== want.index)
               report_error($sformatf("index %0d, expected %0d",
                                      rsp_result_index, want.index));
            if (rsp_result_data !== want.data)
               report_error($sformatf("data 0x%08h, expected 0x%08h",
                                      rsp_result_data, want.data));
            if (rsp_live_count !== want.live)
               report_error($sformatf("live count %0d, expected %0d",
                                      rsp_live_count, want.live));
         end
      end
   end

   task automatic test_empty_pool();
      send_request(FUNC_NEXT, 8'd0, $urandom);
      send_request(FUNC_GET, 8'd0, $urandom);
      send_request(FUNC_REMOVE, 8'd0, $urandom);
      for (int f = FUNC_CLEAR + 1; f < FUNC_CODES; f++)
         send_request(FUNC_W'(f), IDX_W'($urandom), $urandom);
      send_request(FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_basic_ops();
      send_request(FUNC_ADD, 8'hFF, 32'h0000_0000);
      send_request(FUNC_ADD, 8'h00, 32'hFFFF_FFFF);
      send_request(FUNC_ADD, 8'h55, 32'hA5A5_A5A5);
      send_request(FUNC_ADD, 8'hAA, 32'h5A5A_5A5A);
      send_request(FUNC_GET, 8'd3, 32'd0);
      send_request(FUNC_GET, 8'd4, 32'd0);
      send_request(FUNC_REMOVE, 8'd1, 32'd0);
      send_request(FUNC_REMOVE, 8'd1, 32'd0);
      send_request(FUNC_GET, 8'd1, 32'd0);
      send_request(FUNC_NEXT, 8'd1, 32'd0);
      send_request(FUNC_REMOVE, 8'd3, 32'd0);
      send_request(FUNC_GET, 8'd3, 32'd0);
      send_request(FUNC_ADD, 8'd0, 32'h1234_5678);
      send_request(FUNC_NEXT, 8'd255, 32'd0);
      send_request(FUNC_REMOVE, 8'd255, 32'd0);
      send_request(FUNC_GET, 8'd255, 32'd0);
   endtask

   task automatic test_pool_full();
      send_request(FUNC_CLEAR, 8'd0, 32'd0);
      while (high_water < POOL_DEPTH) send_request(FUNC_ADD, IDX_W'($urandom), $urandom);
      send_request(FUNC_ADD, IDX_W'($urandom), $urandom);
      send_request(FUNC_GET, 8'd255, 32'd0);
      send_request(FUNC_NEXT, 8'd255, 32'd0);
      send_request(FUNC_REMOVE, 8'd255, 32'd0);
      send_request(FUNC_ADD, 8'd0, $urandom);
      for (int k = 0; k < 64; k++) send_request(FUNC_REMOVE, IDX_W'(k), $urandom);
      repeat (40) send_request(FUNC_REMOVE, pick_live_slot(), $urandom);
      send_request(FUNC_NEXT, 8'd0, 32'd0);
      repeat (8) send_request(FUNC_NEXT, IDX_W'($urandom), 32'd0);
      send_request(FUNC_REMOVE, 8'd0, 32'd0);
      while (recycle_depth > 0) send_request(FUNC_ADD, IDX_W'($urandom), $urandom);
      send_request(FUNC_ADD, 8'd0, $urandom);
   endtask

   task automatic test_random_mix(input int count, input bit pauses);
      int r;
      int bias;
      sender_pauses = pauses;
      bias = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: bias = 25;
               1: bias = 55;
               default: bias = 85;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r == 0) begin
            send_request(FUNC_CLEAR, IDX_W'($urandom), $urandom);
         end else if (r < 3) begin
            send_request(FUNC_W'($urandom_range(FUNC_CLEAR + 1, FUNC_CODES - 1)),
                         IDX_W'($urandom), $urandom);
         end else if (r < 46) begin
            if ($urandom_range(0, 99) < bias)
               send_request(FUNC_ADD, IDX_W'($urandom), $urandom);
            else
               send_request(FUNC_REMOVE, pick_live_slot(), $urandom);
         end else if (r < 56) begin
            send_request(FUNC_REMOVE, near_slot(), $urandom);
         end else if (r < 78) begin
            send_request(FUNC_GET, $urandom_range(0, 1) ? pick_live_slot() : near_slot(),
                         $urandom);
         end else begin
            send_request(FUNC_NEXT, near_slot(), $urandom);
         end
      end
      sender_pauses = 1'b1;
   endtask

   task automatic finish_run();
      int drain_cycles;
      start <= 1'b0;
      drain_cycles = 0;
      while (expected_results.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (expected_results.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_results.size()));
      repeat (POOL_DEPTH + 8) @(posedge clock);
      $display("Summary: %0d requests (add %0d, remove %0d, get %0d, next %0d, clear %0d)",
               request_count, op_tally[FUNC_ADD], op_tally[FUNC_REMOVE], op_tally[FUNC_GET],
               op_tally[FUNC_NEXT], op_tally[FUNC_CLEAR]);
      $display("Results checked %0d: ok %0d, range %0d, full %0d, already free %0d, none %0d",
               result_count, status_tally[ST_OK], status_tally[ST_RANGE],
               status_tally[ST_FULL], status_tally[ST_FREED], status_tally[ST_NOT_FOUND]);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   endtask

   initial begin
      for (int k = 0; k < POOL_DEPTH; k++) begin
         slot_payload[k] = '0;
         slot_is_free[k] = 1'b0;
         recycle_stack[k] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_pool();
      test_basic_ops();
      test_pool_full();
      test_random_mix(200, 1'b1);
      test_random_mix(160, 1'b0);
      test_random_mix(200, 1'b1);
      finish_run();
   end

   initial begin
      #12_000_000;
      $display("Timed out with %0d results outstanding", expected_results.size());
      $display("FAIL");
      $finish;
   end

endmodule
